[sv/four_level_page_table_walker_core_defines.svh]
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Checks run on the block clock and are masked during reset where noted.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`ifndef SYNTH
// clocked check, masked while reset is high
`define PTW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// clocked check, also live during reset
`define PTW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PTW_ASSERT(label, prop, msg)
`define PTW_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[sv/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// Page table walker package
// Store geometry, entry layout, result codes and the RAM write beat type.
// ----------------------------------------------------------------------------
package ptw_pkg;

   // store geometry
   localparam int TABLE_PAGES  = 64;
   localparam int IDX_BITS     = 9;
   localparam int PAGE_BITS    = $clog2(TABLE_PAGES);
   localparam int FRAME_BITS   = 20;
   localparam int ENTRY_BITS   = FRAME_BITS + 2;
   localparam int ADDR_BITS    = PAGE_BITS + IDX_BITS;

   // fixed field widths
   localparam int TP_BITS      = 6;
   localparam int VP_BITS      = 4 * IDX_BITS;

   // action codes
   localparam logic ACT_WRITE     = 1'b0;
   localparam logic ACT_TRANSLATE = 1'b1;

   // status codes
   localparam logic [1:0] ST_MAPPED   = 2'd0;
   localparam logic [1:0] ST_UNMAPPED = 2'd1;
   localparam logic [1:0] ST_BAD_TBL  = 2'd2;
   localparam logic [1:0] ST_WRITE    = 2'd3;

   // page size codes
   localparam logic [1:0] SZ_NONE = 2'd0;
   localparam logic [1:0] SZ_4K   = 2'd1;
   localparam logic [1:0] SZ_2M   = 2'd2;
   localparam logic [1:0] SZ_1G   = 2'd3;

   // one write beat into the entry RAM
   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [ENTRY_BITS-1:0] data;
   } ram_wr_type;

   // true when a page or frame number names a page held in the store
   function automatic logic in_store(input logic [63:0] num);
      in_store = num < 64'(TABLE_PAGES);
   endfunction

endpackage

[sv/ptw_entry_ram.sv]
// ----------------------------------------------------------------------------
// Entry RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ptw_entry_ram #(
   parameter int ADDR_BITS = 15,
   parameter int DATA_BITS = 22
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem_array [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ptw_clear_sweep.sv]
// ----------------------------------------------------------------------------
// Entry store clear sweep
// After reset writes zero to every RAM entry, one entry per cycle.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_core_defines.svh"

module ptw_clear_sweep (
   input  logic                clock,
   input  logic                reset,
   output logic                clr_busy,
   output ptw_pkg::ram_wr_type clr_wr
);

   logic                          busy_ff;
   logic                          busy_in;
   logic [ptw_pkg::ADDR_BITS-1:0] addr_ff;
   logic [ptw_pkg::ADDR_BITS-1:0] addr_in;

   // address counter, stops after the last entry
   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == '1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign clr_busy    = busy_ff;
   assign clr_wr.en   = busy_ff;
   assign clr_wr.addr = addr_ff;
   assign clr_wr.data = '0;

   `PTW_ASSERT(a_sweep_covers_all, $fell(busy_ff) |-> $past(addr_ff) == '1, "sweep ended early")

endmodule

[sv/ptw_walk_ctrl.sv]
// ----------------------------------------------------------------------------
// Walk controller
// Accepts item beats, writes entries, walks the four table levels through
// the entry RAM and holds the result beat in an output register.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_core_defines.svh"

module ptw_walk_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   // item channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [ptw_pkg::TP_BITS-1:0]    req_table_page,
   input  logic [ptw_pkg::IDX_BITS-1:0]   req_entry_index,
   input  logic                           req_entry_present,
   input  logic                           req_entry_large,
   input  logic [ptw_pkg::FRAME_BITS-1:0] req_entry_frame,
   input  logic [ptw_pkg::VP_BITS-1:0]    req_virt_page_num,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [1:0]                     rsp_page_size_code,
   output logic [ptw_pkg::FRAME_BITS-1:0] rsp_page_frame,
   output logic [ptw_pkg::FRAME_BITS-1:0] rsp_upper_dir_frame,
   output logic [ptw_pkg::FRAME_BITS-1:0] rsp_middle_dir_frame,
   output logic [ptw_pkg::FRAME_BITS-1:0] rsp_leaf_table_frame,
   // root table page and clear sweep state
   input  logic [ptw_pkg::TP_BITS-1:0]    root_table_page,
   input  logic                           clr_busy,
   // entry RAM
   output ptw_pkg::ram_wr_type            walk_wr,
   output logic                           rd_en,
   output logic [ptw_pkg::ADDR_BITS-1:0]  rd_addr,
   input  logic [ptw_pkg::ENTRY_BITS-1:0] rd_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   // level of the entry coming back from the RAM
   localparam logic [1:0] LVL_TOP    = 2'd3;
   localparam logic [1:0] LVL_UPPER  = 2'd2;
   localparam logic [1:0] LVL_MIDDLE = 2'd1;
   localparam logic [1:0] LVL_LEAF   = 2'd0;

   localparam int IB = ptw_pkg::IDX_BITS;

   logic [1:0]                     state_ff, state_in;
   logic [1:0]                     lvl_ff, lvl_in;
   logic [ptw_pkg::VP_BITS-1:0]    vp_ff, vp_in;
   logic [1:0]                     status_ff, status_in;
   logic [1:0]                     size_ff, size_in;
   logic [ptw_pkg::FRAME_BITS-1:0] page_ff, page_in;
   logic [ptw_pkg::FRAME_BITS-1:0] upper_ff, upper_in;
   logic [ptw_pkg::FRAME_BITS-1:0] middle_ff, middle_in;
   logic [ptw_pkg::FRAME_BITS-1:0] leaf_ff, leaf_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff;
   logic [1:0]                     rsp_size_ff;
   logic [ptw_pkg::FRAME_BITS-1:0] rsp_page_ff;
   logic [ptw_pkg::FRAME_BITS-1:0] rsp_upper_ff;
   logic [ptw_pkg::FRAME_BITS-1:0] rsp_middle_ff;
   logic [ptw_pkg::FRAME_BITS-1:0] rsp_leaf_ff;

   logic                           accept;
   logic                           out_free;
   logic                           out_load;
   logic                           e_present;
   logic                           e_large;
   logic [ptw_pkg::FRAME_BITS-1:0] e_frame;
   logic                           e_frame_ok;
   logic [ptw_pkg::PAGE_BITS-1:0]  e_page;

   // handshakes
   assign req_stall = clr_busy || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == S_FIN) && out_free;

   // entry returned by the RAM
   assign e_present  = rd_data[0];
   assign e_large    = rd_data[1];
   assign e_frame    = rd_data[ptw_pkg::ENTRY_BITS-1:2];
   assign e_frame_ok = ptw_pkg::in_store(64'(e_frame));
   assign e_page     = ptw_pkg::PAGE_BITS'(e_frame);

   // walk sequencer
   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      vp_in        = vp_ff;
      status_in    = status_ff;
      size_in      = size_ff;
      page_in      = page_ff;
      upper_in     = upper_ff;
      middle_in    = middle_ff;
      leaf_in      = leaf_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      walk_wr.en   = 1'b0;
      walk_wr.addr = '0;
      walk_wr.data = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               vp_in     = req_virt_page_num;
               status_in = ptw_pkg::ST_UNMAPPED;
               size_in   = ptw_pkg::SZ_NONE;
               page_in   = '0;
               upper_in  = '0;
               middle_in = '0;
               leaf_in   = '0;
               state_in  = S_FIN;
               if (req_action == ptw_pkg::ACT_WRITE) begin
                  walk_wr.en   = ptw_pkg::in_store(64'(req_table_page));
                  walk_wr.addr = {ptw_pkg::PAGE_BITS'(req_table_page), req_entry_index};
                  walk_wr.data = {req_entry_frame, req_entry_large, req_entry_present};
                  status_in    = ptw_pkg::ST_WRITE;
               end else if (!ptw_pkg::in_store(64'(root_table_page))) begin
                  status_in = ptw_pkg::ST_BAD_TBL;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = {ptw_pkg::PAGE_BITS'(root_table_page),
                              req_virt_page_num[4*IB-1:3*IB]};
                  lvl_in   = LVL_TOP;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            state_in = S_FIN;
            unique case (lvl_ff)
               LVL_TOP: begin
                  if (e_present) begin
                     upper_in = e_frame;
                     if (e_frame_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = {e_page, vp_ff[3*IB-1:2*IB]};
                        lvl_in   = LVL_UPPER;
                        state_in = S_WALK;
                     end else begin
                        status_in = ptw_pkg::ST_BAD_TBL;
                     end
                  end
               end
               LVL_UPPER: begin
                  if (e_present && !e_large) begin
                     middle_in = e_frame;
                     if (e_frame_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = {e_page, vp_ff[2*IB-1:IB]};
                        lvl_in   = LVL_MIDDLE;
                        state_in = S_WALK;
                     end else begin
                        status_in = ptw_pkg::ST_BAD_TBL;
                     end
                  end else if (e_present) begin
                     status_in = ptw_pkg::ST_MAPPED;
                     size_in   = ptw_pkg::SZ_1G;
                     page_in   = e_frame;
                  end
               end
               LVL_MIDDLE: begin
                  if (e_present && !e_large) begin
                     leaf_in = e_frame;
                     if (e_frame_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = {e_page, vp_ff[IB-1:0]};
                        lvl_in   = LVL_LEAF;
                        state_in = S_WALK;
                     end else begin
                        status_in = ptw_pkg::ST_BAD_TBL;
                     end
                  end else if (e_present) begin
                     status_in = ptw_pkg::ST_MAPPED;
                     size_in   = ptw_pkg::SZ_2M;
                     page_in   = e_frame;
                  end
               end
               LVL_LEAF: begin
                  if (e_present) begin
                     status_in = ptw_pkg::ST_MAPPED;
                     size_in   = ptw_pkg::SZ_4K;
                     page_in   = e_frame;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result beat register
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      vp_ff     <= vp_in;
      status_ff <= status_in;
      size_ff   <= size_in;
      page_ff   <= page_in;
      upper_ff  <= upper_in;
      middle_ff <= middle_in;
      leaf_ff   <= leaf_in;
      if (out_load) begin
         rsp_status_ff <= status_ff;
         rsp_size_ff   <= size_ff;
         rsp_page_ff   <= page_ff;
         rsp_upper_ff  <= upper_ff;
         rsp_middle_ff <= middle_ff;
         rsp_leaf_ff   <= leaf_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_page_size_code   = rsp_size_ff;
   assign rsp_page_frame       = rsp_page_ff;
   assign rsp_upper_dir_frame  = rsp_upper_ff;
   assign rsp_middle_dir_frame = rsp_middle_ff;
   assign rsp_leaf_table_frame = rsp_leaf_ff;

   `PTW_ASSERT(a_write_rsp_clean, rsp_valid_ff && (rsp_status_ff == ptw_pkg::ST_WRITE) |-> (rsp_size_ff == ptw_pkg::SZ_NONE) && (rsp_page_ff == '0) && (rsp_upper_ff == '0) && (rsp_leaf_ff == '0), "write beat carries walk data")
   `PTW_ASSERT(a_mapped_has_size, rsp_valid_ff && (rsp_status_ff == ptw_pkg::ST_MAPPED) |-> rsp_size_ff != ptw_pkg::SZ_NONE, "mapped result without page size")
   `PTW_ASSERT(a_no_read_in_sweep, rd_en |-> !clr_busy, "RAM read during clear sweep")
   `PTW_ASSERT(a_level_steps_down, (state_ff == S_WALK) && (state_in == S_WALK) |=> lvl_ff == $past(lvl_ff) - 2'd1, "walk level did not step down")

endmodule

[sv/four_level_page_table_walker_core.sv]
// A write beat writes the entry RAM when accepted and goes to the finish state; a
// translation first issues one dependent entry RAM read per level it reaches. No
// new item is accepted until the finish state has loaded the result register.
// The next item is accepted while the previous result still waits in its register.
// Reset (synchronous) clears the root register and starts a clear sweep of all
// 32768 entries, one per cycle; items are stalled until the sweep is done.
// ----------------------------------------------------------------------------
// Four-level page table walker core
// Entry store in a single RAM, clear sweep after reset, walk controller
// and root table page register.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_core (
   input  logic        clock,
   input  logic        reset,
   // item channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [5:0]  req_table_page,
   input  logic [8:0]  req_entry_index,
   input  logic        req_entry_present,
   input  logic        req_entry_large,
   input  logic [19:0] req_entry_frame,
   input  logic [35:0] req_virt_page_num,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_page_size_code,
   output logic [19:0] rsp_page_frame,
   output logic [19:0] rsp_upper_dir_frame,
   output logic [19:0] rsp_middle_dir_frame,
   output logic [19:0] rsp_leaf_table_frame,
   // configuration
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   logic [ptw_pkg::TP_BITS-1:0]    root_table_page_ff;
   logic                           clr_busy;
   ptw_pkg::ram_wr_type            clr_wr;
   ptw_pkg::ram_wr_type            walk_wr;
   ptw_pkg::ram_wr_type            ram_wr;
   logic                           rd_en;
   logic [ptw_pkg::ADDR_BITS-1:0]  rd_addr;
   logic [ptw_pkg::ENTRY_BITS-1:0] rd_data;

   // root table page register
   always_ff @(posedge clock) begin
      if (reset) begin
         root_table_page_ff <= '0;
      end else if (csr_wr_en) begin
         root_table_page_ff <= csr_wr_data;
      end
   end

   // RAM write port: sweep owns it until done
   assign ram_wr = clr_busy ? clr_wr : walk_wr;

   ptw_clear_sweep u_sweep (
      .clock    (clock),
      .reset    (reset),
      .clr_busy (clr_busy),
      .clr_wr   (clr_wr)
   );

   ptw_entry_ram #(
      .ADDR_BITS (ptw_pkg::ADDR_BITS),
      .DATA_BITS (ptw_pkg::ENTRY_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptw_walk_ctrl u_walk (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_table_page       (req_table_page),
      .req_entry_index      (req_entry_index),
      .req_entry_present    (req_entry_present),
      .req_entry_large      (req_entry_large),
      .req_entry_frame      (req_entry_frame),
      .req_virt_page_num    (req_virt_page_num),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_page_size_code   (rsp_page_size_code),
      .rsp_page_frame       (rsp_page_frame),
      .rsp_upper_dir_frame  (rsp_upper_dir_frame),
      .rsp_middle_dir_frame (rsp_middle_dir_frame),
      .rsp_leaf_table_frame (rsp_leaf_table_frame),
      .root_table_page      (root_table_page_ff),
      .clr_busy             (clr_busy),
      .walk_wr              (walk_wr),
      .rd_en                (rd_en),
      .rd_addr              (rd_addr),
      .rd_data              (rd_data)
   );

endmodule

[tb/tb_four_level_page_table_walker_core.sv]
// ----------------------------------------------------------------------------
// Four-level page table walker testbench
// Builds page-table chains in the entry store, translates through them under
// several root table settings, checks every result beat against a local walk
// predictor or a fixed result, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_core;

   localparam int DIR_ROWS         = 24;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_BEATS      = 200;
   localparam int LONG_HOLD_CYCLES = 300;

   // short names for the action codes used in the table below
   localparam logic ACT_WR = ptw_pkg::ACT_WRITE;
   localparam logic ACT_TR = ptw_pkg::ACT_TRANSLATE;

   // one request beat and one result beat
   typedef struct {
      logic        action;
      logic [5:0]  table_page;
      logic [8:0]  entry_index;
      logic        entry_present;
      logic        entry_large;
      logic [19:0] entry_frame;
      logic [35:0] virt_page_num;
   } walk_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  page_size_code;
      logic [19:0] page_frame;
      logic [19:0] upper_dir_frame;
      logic [19:0] middle_dir_frame;
      logic [19:0] leaf_table_frame;
   } walk_rsp_type;

   // mirrored table entry, all zero means not present
   typedef struct packed {
      bit [19:0] frame;
      bit        is_large;
      bit        present;
   } pte_type;

   // directed row: root setting, request fields, optional fixed result
   typedef struct packed {
      logic [5:0]   root;
      logic         action;
      logic [5:0]   table_page;
      logic [8:0]   entry_index;
      logic         entry_present;
      logic         entry_large;
      logic [19:0]  entry_frame;
      logic [35:0]  virt_page_num;
      logic         typed;
      walk_rsp_type want;
   } dir_row_type;

   localparam walk_rsp_type WR_DONE =
      '{ptw_pkg::ST_WRITE, ptw_pkg::SZ_NONE, 20'd0, 20'd0, 20'd0, 20'd0};
   localparam walk_rsp_type NO_MAP  =
      '{ptw_pkg::ST_UNMAPPED, ptw_pkg::SZ_NONE, 20'd0, 20'd0, 20'd0, 20'd0};
   localparam walk_rsp_type BAD_UPR =
      '{ptw_pkg::ST_BAD_TBL, ptw_pkg::SZ_NONE, 20'd0, 20'hFFFFF, 20'd0, 20'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ptw_pkg::ACT_WRITE;
   logic [5:0]  req_table_page = '0;
   logic [8:0]  req_entry_index = '0;
   logic        req_entry_present = 1'b0;
   logic        req_entry_large = 1'b0;
   logic [19:0] req_entry_frame = '0;
   logic [35:0] req_virt_page_num = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_page_size_code;
   logic [19:0] rsp_page_frame;
   logic [19:0] rsp_upper_dir_frame;
   logic [19:0] rsp_middle_dir_frame;
   logic [19:0] rsp_leaf_table_frame;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   // predictor state and scoreboard
   pte_type      entry_mirror [ptw_pkg::TABLE_PAGES][512];
   logic [5:0]   root_now = '0;
   walk_rsp_type expected_walks [$];
   int           mismatches = 0;
   int           beats_sent = 0;
   int           root_writes = 0;
   int           status_seen [4] = '{0, 0, 0, 0};
   int           size_seen [4] = '{0, 0, 0, 0};

   // idling controls
   int          tx_gap_max = 3;
   int          rx_gap_max = 3;
   int          rx_wait = 0;
   logic        hold_request = 1'b0;
   logic        long_hold = 1'b0;

   // directed rows; typed rows carry a result readable at a glance
   dir_row_type directed_rows [DIR_ROWS] = '{
      // empty store after reset
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0, 36'd0, 1'b1, NO_MAP},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0, '1, 1'b1, NO_MAP},
      // full 4 KiB chain 0 -> 1 -> 2 -> 3, top and leaf large bits set
      '{6'd0, ACT_WR, 6'd0, 9'd0, 1'b1, 1'b1, 20'd1, '1, 1'b1, WR_DONE},
      '{6'd0, ACT_WR, 6'd1, 9'd0, 1'b1, 1'b0, 20'd2, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_WR, 6'd2, 9'd0, 1'b1, 1'b0, 20'd3, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_WR, 6'd3, 9'd0, 1'b1, 1'b1, 20'hFFFFF, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0, 36'd0, 1'b0, '0},
      // 2 MiB page
      '{6'd0, ACT_WR, 6'd2, 9'd1, 1'b1, 1'b1, 20'hABCDE, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0,
        {9'd0, 9'd0, 9'd1, 9'd511}, 1'b0, '0},
      // 1 GiB page at frame zero
      '{6'd0, ACT_WR, 6'd1, 9'd511, 1'b1, 1'b1, 20'd0, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0,
        {9'd0, 9'd511, 9'd255, 9'd255}, 1'b0, '0},
      // second-level table frame outside the store
      '{6'd0, ACT_WR, 6'd0, 9'd511, 1'b1, 1'b0, 20'hFFFFF, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0,
        {9'd511, 9'd0, 9'd0, 9'd0}, 1'b1, BAD_UPR},
      // third-level table frame just past the store
      '{6'd0, ACT_WR, 6'd1, 9'd5, 1'b1, 1'b0, 20'd64, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0,
        {9'd0, 9'd5, 9'd0, 9'd0}, 1'b0, '0},
      // last-level table at the top page, empty entry
      '{6'd0, ACT_WR, 6'd2, 9'd7, 1'b1, 1'b0, 20'd63, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0,
        {9'd0, 9'd0, 9'd7, 9'd0}, 1'b0, '0},
      // last-level table frame outside the store
      '{6'd0, ACT_WR, 6'd2, 9'd8, 1'b1, 1'b0, 20'd100, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0,
        {9'd0, 9'd0, 9'd8, 9'd3}, 1'b0, '0},
      // top entry cleared, frame left nonzero
      '{6'd0, ACT_WR, 6'd0, 9'd0, 1'b0, 1'b1, 20'd1, 36'd0, 1'b1, WR_DONE},
      '{6'd0, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0, 36'd0, 1'b1, NO_MAP},
      // root at the last store page
      '{6'd63, ACT_WR, 6'd63, 9'd511, 1'b1, 1'b0, 20'd1, 36'd0, 1'b1, WR_DONE},
      '{6'd63, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0,
        {9'd511, 9'd0, 9'd0, 9'd0}, 1'b0, '0},
      '{6'd63, ACT_TR, 6'd0, 9'd0, 1'b0, 1'b0, 20'd0, 36'd0, 1'b1, NO_MAP}
   };

   four_level_page_table_walker_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_table_page       (req_table_page),
      .req_entry_index      (req_entry_index),
      .req_entry_present    (req_entry_present),
      .req_entry_large      (req_entry_large),
      .req_entry_frame      (req_entry_frame),
      .req_virt_page_num    (req_virt_page_num),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_page_size_code   (rsp_page_size_code),
      .rsp_page_frame       (rsp_page_frame),
      .rsp_upper_dir_frame  (rsp_upper_dir_frame),
      .rsp_middle_dir_frame (rsp_middle_dir_frame),
      .rsp_leaf_table_frame (rsp_leaf_table_frame),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // applies one beat to the mirror: stores a write or walks the four levels
   function automatic walk_rsp_type predict_walk(input walk_req_type r);
      walk_rsp_type res;
      pte_type      e;
      logic [19:0]  tbl;
      res = NO_MAP;
      tbl = 20'(root_now);
      if (r.action == ptw_pkg::ACT_WRITE) begin
         entry_mirror[r.table_page][r.entry_index] =
            '{r.entry_frame, r.entry_large, r.entry_present};
         return WR_DONE;
      end
      for (int lvl = 0; lvl < 4; lvl++) begin
         e = entry_mirror[tbl[5:0]][r.virt_page_num[35-9*lvl -: 9]];
         if (!e.present) break;
         // top-level large bit is ignored, last level is always a page
         if (lvl == 3 || (lvl != 0 && e.is_large)) begin
            res.status = ptw_pkg::ST_MAPPED;
            res.page_size_code = (lvl == 3) ? ptw_pkg::SZ_4K :
                                 (lvl == 2) ? ptw_pkg::SZ_2M : ptw_pkg::SZ_1G;
            res.page_frame = e.frame;
            break;
         end
         case (lvl)
            0: res.upper_dir_frame = e.frame;
            1: res.middle_dir_frame = e.frame;
            default: res.leaf_table_frame = e.frame;
         endcase
         if (e.frame >= ptw_pkg::TABLE_PAGES) begin
            res.status = ptw_pkg::ST_BAD_TBL;
            break;
         end
         tbl = e.frame;
      end
      return res;
   endfunction

   function automatic walk_req_type random_req();
      walk_req_type r;
      r.action        = 1'($urandom);
      r.table_page    = 6'($urandom);
      r.entry_index   = 9'($urandom);
      r.entry_present = 1'($urandom);
      r.entry_large   = 1'($urandom);
      r.entry_frame   = 20'($urandom);
      r.virt_page_num = {4'($urandom), 32'($urandom)};
      return r;
   endfunction

   // offer one beat after a random gap, record its result once accepted
   task automatic send_beat(input walk_req_type r, input logic typed,
                            input walk_rsp_type fixed);
      walk_rsp_type model;
      int           gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= r.action;
      req_table_page    <= r.table_page;
      req_entry_index   <= r.entry_index;
      req_entry_present <= r.entry_present;
      req_entry_large   <= r.entry_large;
      req_entry_frame   <= r.entry_frame;
      req_virt_page_num <= r.virt_page_num;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model = predict_walk(r);
      status_seen[model.status]++;
      size_seen[model.page_size_code]++;
      expected_walks.push_back(typed ? fixed : model);
      beats_sent++;
   endtask

   task automatic drain_walks();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_walks.size() != 0) @(posedge clock);
   endtask

   task automatic set_root(input logic [5:0] page);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= page;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      root_now = page;
      root_writes++;
   endtask

   // build a chain from the root down, then translate through it
   task automatic run_walk_sequence();
      walk_req_type r;
      logic [35:0]  va;
      logic [5:0]   tbl;
      logic [19:0]  frame;
      logic         is_large;
      int           depth;
      int           n_walks;
      va    = {4'($urandom), 32'($urandom)};
      tbl   = root_now;
      depth = $urandom_range(1, 4);
      for (int lvl = 0; lvl < depth; lvl++) begin
         if (lvl == 0 || lvl == 3) is_large = 1'($urandom);
         else if (lvl == depth - 1) is_large = ($urandom_range(0, 5) != 0);
         else is_large = ($urandom_range(0, 9) == 0);
         if (lvl == 3 || (lvl != 0 && is_large)) begin
            frame = 20'($urandom);
         end else begin
            case ($urandom_range(0, 15))
               0: frame = 20'($urandom);
               1: frame = 20'($urandom_range(64, 127));
               default: frame = 20'($urandom_range(0, 63));
            endcase
         end
         r = random_req();
         r.action        = ptw_pkg::ACT_WRITE;
         r.table_page    = tbl;
         r.entry_index   = va[35-9*lvl -: 9];
         r.entry_present = ($urandom_range(0, 11) != 0);
         r.entry_large   = is_large;
         r.entry_frame   = frame;
         send_beat(r, 1'b0, '0);
         if (frame >= ptw_pkg::TABLE_PAGES || lvl == 3 || (lvl != 0 && is_large)) break;
         tbl = frame[5:0];
      end
      n_walks = $urandom_range(1, 3);
      for (int k = 0; k < n_walks; k++) begin
         r = random_req();
         r.action = ptw_pkg::ACT_TRANSLATE;
         r.virt_page_num = va;
         // neighbors of the mapped page
         if (k != 0 && $urandom_range(0, 1) == 1)
            r.virt_page_num[9*$urandom_range(0, 3) +: 9] = 9'($urandom);
         send_beat(r, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic [19:0] want,
                              input logic [19:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result side: check each beat, then stall for a random number of cycles
   always @(posedge clock) begin : rsp_sink
      walk_rsp_type got;
      walk_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = '{rsp_status, rsp_page_size_code, rsp_page_frame, rsp_upper_dir_frame,
                 rsp_middle_dir_frame, rsp_leaf_table_frame};
         if (expected_walks.size() == 0) begin
            $display("%0t: result beat with nothing pending, expected none, actual status %0d",
                     $time, got.status);
            mismatches++;
         end else begin
            want = expected_walks.pop_front();
            check_field("status", 20'(want.status), 20'(got.status));
            check_field("page_size_code", 20'(want.page_size_code),
                        20'(got.page_size_code));
            check_field("page_frame", want.page_frame, got.page_frame);
            check_field("upper_dir_frame", want.upper_dir_frame, got.upper_dir_frame);
            check_field("middle_dir_frame", want.middle_dir_frame, got.middle_dir_frame);
            check_field("leaf_table_frame", want.leaf_table_frame, got.leaf_table_frame);
         end
         rx_wait = $urandom_range(0, rx_gap_max);
      end else if (rx_wait != 0) begin
         rx_wait--;
      end
      rsp_stall <= long_hold || (rx_wait != 0);
   end

   // one long receiver hold-off so the block backs up into its input
   initial begin : rsp_long_hold
      wait (hold_request === 1'b1);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin : stimulus
      walk_req_type r;
      int           phase_end;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows, root rewritten only with nothing in flight
      foreach (directed_rows[i]) begin
         if (directed_rows[i].root != root_now) begin
            drain_walks();
            set_root(directed_rows[i].root);
         end
         r.action        = directed_rows[i].action;
         r.table_page    = directed_rows[i].table_page;
         r.entry_index   = directed_rows[i].entry_index;
         r.entry_present = directed_rows[i].entry_present;
         r.entry_large   = directed_rows[i].entry_large;
         r.entry_frame   = directed_rows[i].entry_frame;
         r.virt_page_num = directed_rows[i].virt_page_num;
         send_beat(r, directed_rows[i].typed, directed_rows[i].want);
      end

      // random phases, each under its own root and idling mix
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_walks();
         if (phase == 0) set_root(6'd63);
         else if (phase == 1) set_root(6'd0);
         else set_root(6'($urandom));
         if (phase == 3) begin
            tx_gap_max = 0;
            rx_gap_max <= 0;
            hold_request <= 1'b1;
         end else begin
            tx_gap_max = (phase % 3 == 1) ? 0 : 11;
            rx_gap_max <= (phase % 4 == 2) ? 0 : 11;
         end
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 9) < 7) run_walk_sequence();
            else send_beat(random_req(), 1'b0, '0);
         end
      end

      drain_walks();
      repeat (20) @(posedge clock);
      $display("covered %0d beats under %0d root settings: %0d writes, %0d mapped,",
               beats_sent, root_writes + 1, status_seen[ptw_pkg::ST_WRITE],
               status_seen[ptw_pkg::ST_MAPPED]);
      $display("  %0d unmapped, %0d bad table; pages found: %0d of 4 KiB, %0d of 2 MiB, %0d of 1 GiB",
               status_seen[ptw_pkg::ST_UNMAPPED], status_seen[ptw_pkg::ST_BAD_TBL],
               size_seen[ptw_pkg::SZ_4K], size_seen[ptw_pkg::SZ_2M],
               size_seen[ptw_pkg::SZ_1G]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
